// File: hdl/assert_macros.svh
// assertion macros shared by the merge block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, suspended while reset is held
`define STWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define STWM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/stwm_pkg.sv
// package with types and constants of the two-way merge block
`timescale 1ns / 1ps

package stwm_pkg;

  // element width
  localparam int VALUE_W = 32;

  // default queue depth per list
  localparam int QUEUE_DEPTH_DEF = 32;

  // results emitted per input transaction at most
  localparam int MAX_RESULTS = 32;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // queue status seen by the compare unit
  typedef struct packed {
    logic nz_a;
    logic nz_b;
    logic ended_a;
    logic ended_b;
  } qstat_t;

  // decision of the compare unit
  typedef struct packed {
    logic take;
    logic take_a;
  } pick_t;

endpackage

// File: hdl/stwm_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module stwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/stwm_pick.sv
// compare unit: picks which queue head goes out next
`timescale 1ns / 1ps

module stwm_pick (
  input  stwm_pkg::qstat_t                   st,
  input  logic signed [stwm_pkg::VALUE_W-1:0] head_a,
  input  logic signed [stwm_pkg::VALUE_W-1:0] head_b,
  output stwm_pkg::pick_t                    pk
);

  logic a_le_b;

  // signed compare, list a wins a tie
  assign a_le_b = (head_a <= head_b);

  // emit only when the choice is safe
  always_comb begin
    pk.take   = 1'b0;
    pk.take_a = 1'b0;
    if (st.nz_a && st.nz_b) begin
      pk.take   = 1'b1;
      pk.take_a = a_le_b;
    end else if (st.nz_a && st.ended_b) begin
      pk.take   = 1'b1;
      pk.take_a = 1'b1;
    end else if (st.nz_b && st.ended_a) begin
      pk.take   = 1'b1;
      pk.take_a = 1'b0;
    end
  end

endmodule

// File: hdl/sorted_two_way_merge.sv
// top level: sequencer, queue rams and compare unit of the two-way merge
// an accepted transaction that causes no result returns to ready after fetch and compare
// each result passes through its steps in order, plus any output stall
// (head fetch from the queue ram, compare and load, output handshake)
// no new input transaction is taken until the current one has emitted all its results,
// up to 32 results
// reset is synchronous, active low; queue contents stay undefined, no clearing pass
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_two_way_merge #(
  parameter int QUEUE_DEPTH = stwm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [stwm_pkg::VALUE_W-1:0] in_value,
  input  logic                                in_list_id,
  input  logic                                in_is_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [stwm_pkg::VALUE_W-1:0] out_merged_value,
  output logic                                out_has_value,
  output logic                                out_is_last,
  output logic                                out_overflow
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int VW = stwm_pkg::VALUE_W;
  localparam int RW = stwm_pkg::RES_CNT_W;

  localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
  localparam logic [SW-1:0] DEPTH_S  = SW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] HEAD_MAX = AW'(QUEUE_DEPTH - 1);
  localparam logic [RW-1:0] RES_MAX  = RW'(stwm_pkg::MAX_RESULTS);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [RW-1:0] RES_ONE  = RW'(1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [AW-1:0] head_a_r, head_a_nxt, head_b_r, head_b_nxt;
  logic          end_a_r, end_a_nxt, end_b_r, end_b_nxt;
  logic          drop_r, drop_nxt;
  logic          fin_r, fin_nxt;
  logic [RW-1:0] res_cnt_r, res_cnt_nxt;

  logic signed [VW-1:0] val_r, val_nxt;
  logic                 has_r, has_nxt;
  logic                 last_r, last_nxt;
  logic                 ovf_r, ovf_nxt;

  logic          we_a, we_b;
  logic [SW-1:0] wsum_a, wsum_b;
  logic [AW-1:0] waddr_a, waddr_b;
  logic [VW-1:0] rd_a, rd_b;
  logic          emit_last;

  stwm_pkg::qstat_t st;
  stwm_pkg::pick_t  pk;

  // tail address: head plus count, wrapped once
  always_comb begin
    wsum_a = SW'(head_a_r) + SW'(cnt_a_r);
    wsum_b = SW'(head_b_r) + SW'(cnt_b_r);
    if (wsum_a >= DEPTH_S) begin
      wsum_a = wsum_a - DEPTH_S;
    end
    if (wsum_b >= DEPTH_S) begin
      wsum_b = wsum_b - DEPTH_S;
    end
    waddr_a = wsum_a[AW-1:0];
    waddr_b = wsum_b[AW-1:0];
  end

  // queue storage, read at the head position
  stwm_ram #(.WIDTH(VW), .DEPTH(QUEUE_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata (in_value),
    .raddr (head_a_r),
    .rdata (rd_a)
  );

  stwm_ram #(.WIDTH(VW), .DEPTH(QUEUE_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr_b),
    .wdata (in_value),
    .raddr (head_b_r),
    .rdata (rd_b)
  );

  // shared compare unit
  assign st.nz_a    = (cnt_a_r != '0);
  assign st.nz_b    = (cnt_b_r != '0);
  assign st.ended_a = end_a_r;
  assign st.ended_b = end_b_r;

  stwm_pick u_pick (
    .st     (st),
    .head_a ($signed(rd_a)),
    .head_b ($signed(rd_b)),
    .pk     (pk)
  );

  // popped element closes the run when both lists ended and nothing else waits
  assign emit_last = end_a_r && end_b_r &&
                     (pk.take_a ? (cnt_a_r == CNT_ONE && cnt_b_r == '0)
                                : (cnt_b_r == CNT_ONE && cnt_a_r == '0));

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_a_nxt   = cnt_a_r;
    cnt_b_nxt   = cnt_b_r;
    head_a_nxt  = head_a_r;
    head_b_nxt  = head_b_r;
    end_a_nxt   = end_a_r;
    end_b_nxt   = end_b_r;
    drop_nxt    = drop_r;
    fin_nxt     = fin_r;
    res_cnt_nxt = res_cnt_r;
    val_nxt     = val_r;
    has_nxt     = has_r;
    last_nxt    = last_r;
    ovf_nxt     = ovf_r;
    we_a        = 1'b0;
    we_b        = 1'b0;
    case (state_r)
      // take one transaction: push or end marker
      S_IDLE: begin
        if (in_valid) begin
          drop_nxt    = 1'b0;
          fin_nxt     = 1'b0;
          res_cnt_nxt = '0;
          if (in_is_end) begin
            if (!in_list_id) begin
              end_a_nxt = 1'b1;
            end else begin
              end_b_nxt = 1'b1;
            end
          end else if (!in_list_id) begin
            if (end_a_r || cnt_a_r >= DEPTH_C) begin
              drop_nxt = 1'b1;
            end else begin
              we_a      = 1'b1;
              cnt_a_nxt = cnt_a_r + CNT_ONE;
            end
          end else begin
            if (end_b_r || cnt_b_r >= DEPTH_C) begin
              drop_nxt = 1'b1;
            end else begin
              we_b      = 1'b1;
              cnt_b_nxt = cnt_b_r + CNT_ONE;
            end
          end
          state_nxt = S_FETCH;
        end
      end
      // ram reads the current heads
      S_FETCH: begin
        state_nxt = S_EMIT;
      end
      // compare heads and load one result, an empty end or drop result, or go idle
      S_EMIT: begin
        if (pk.take && res_cnt_r < RES_MAX) begin
          val_nxt     = pk.take_a ? $signed(rd_a) : $signed(rd_b);
          has_nxt     = 1'b1;
          last_nxt    = emit_last;
          ovf_nxt     = drop_r && (res_cnt_r == '0);
          res_cnt_nxt = res_cnt_r + RES_ONE;
          if (pk.take_a) begin
            cnt_a_nxt  = cnt_a_r - CNT_ONE;
            head_a_nxt = (head_a_r == HEAD_MAX) ? '0 : head_a_r + AW'(1);
          end else begin
            cnt_b_nxt  = cnt_b_r - CNT_ONE;
            head_b_nxt = (head_b_r == HEAD_MAX) ? '0 : head_b_r + AW'(1);
          end
          if (emit_last) begin
            end_a_nxt  = 1'b0;
            end_b_nxt  = 1'b0;
            head_a_nxt = '0;
            head_b_nxt = '0;
            fin_nxt    = 1'b1;
          end
          state_nxt = S_OUT;
        end else if (end_a_r && end_b_r && cnt_a_r == '0 && cnt_b_r == '0) begin
          // empty end result
          val_nxt     = '0;
          has_nxt     = 1'b0;
          last_nxt    = 1'b1;
          ovf_nxt     = drop_r;
          res_cnt_nxt = res_cnt_r + RES_ONE;
          end_a_nxt   = 1'b0;
          end_b_nxt   = 1'b0;
          head_a_nxt  = '0;
          head_b_nxt  = '0;
          fin_nxt     = 1'b1;
          state_nxt   = S_OUT;
        end else if (drop_r && res_cnt_r == '0) begin
          // dropped push with nothing to emit
          val_nxt     = '0;
          has_nxt     = 1'b0;
          last_nxt    = 1'b0;
          ovf_nxt     = 1'b1;
          res_cnt_nxt = res_cnt_r + RES_ONE;
          fin_nxt     = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      // hold the result until taken
      S_OUT: begin
        if (out_ready) begin
          state_nxt = fin_r ? S_IDLE : S_FETCH;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_a_r   <= '0;
      cnt_b_r   <= '0;
      head_a_r  <= '0;
      head_b_r  <= '0;
      end_a_r   <= 1'b0;
      end_b_r   <= 1'b0;
      drop_r    <= 1'b0;
      fin_r     <= 1'b0;
      res_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_a_r   <= cnt_a_nxt;
      cnt_b_r   <= cnt_b_nxt;
      head_a_r  <= head_a_nxt;
      head_b_r  <= head_b_nxt;
      end_a_r   <= end_a_nxt;
      end_b_r   <= end_b_nxt;
      drop_r    <= drop_nxt;
      fin_r     <= fin_nxt;
      res_cnt_r <= res_cnt_nxt;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    has_r  <= has_nxt;
    last_r <= last_nxt;
    ovf_r  <= ovf_nxt;
  end

  // ports
  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = (state_r == S_OUT);
  assign out_merged_value = val_r;
  assign out_has_value    = has_r;
  assign out_is_last      = last_r;
  assign out_overflow     = ovf_r;

  // checks
  `STWM_ASSERT(a_cnt_bound, (cnt_a_r <= DEPTH_C && cnt_b_r <= DEPTH_C), "queue count above depth")
  `STWM_ASSERT(a_one_side, (!(in_ready && out_valid)), "input and output active together")
  `STWM_ASSERT(a_last_clears, ((out_valid && out_ready && out_is_last) |=> (!end_a_r && !end_b_r && head_a_r == '0 && head_b_r == '0)), "run state kept after last result")
  `STWM_ASSERT(a_ovf_first, ((out_valid && out_overflow) |-> (res_cnt_r == RES_ONE && drop_r)), "overflow flagged past first result")

endmodule
